### hw/rtl/shared_page_group_table_assert.svh
// ----------------------------------------------------------------------------
// shared_page_group_table assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHARED_PAGE_GROUP_TABLE_ASSERT_SVH
`define SHARED_PAGE_GROUP_TABLE_ASSERT_SVH

`ifndef SYNTH
`define SPGT_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spgt check failed");
`define SPGT_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spgt check failed");
`else
`define SPGT_CHECK(lbl, ante, cons)
`define SPGT_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/spgt_pkg.sv
// ----------------------------------------------------------------------------
// spgt_pkg
// item types, codes and defaults for the shared page group table
// ----------------------------------------------------------------------------
package spgt_pkg;

    localparam int GROUP_SLOTS_DEF     = 64;
    localparam int PAGES_PER_GROUP_DEF = 128;

    localparam int COUNT_W = 7;
    localparam int GROUP_W = 16;
    localparam int ADDR_W  = 56;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd64;
    localparam logic [GROUP_W-1:0] NO_GROUP  = 16'hFFFF;

    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_TEST   = 3'd2;
    localparam logic [2:0] ACT_INC    = 3'd3;
    localparam logic [2:0] ACT_DEC    = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_GROUP   = 2'd1;
    localparam logic [1:0] ST_LIST_FULL  = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]                action;
        logic signed [GROUP_W-1:0] group_id;
        logic [ADDR_W-1:0]         page_addr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               is_member;
        logic [COUNT_W-1:0] proc_count;
    } out_item_t;

endpackage

### hw/rtl/spgt_ram.sv
// ----------------------------------------------------------------------------
// spgt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module spgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/spgt_seq.sv
// ----------------------------------------------------------------------------
// spgt_seq
// operation sequencer: slot scan, page scan and read-modify-write of both rams
// ----------------------------------------------------------------------------
module spgt_seq #(
    parameter int GROUP_SLOTS     = 64,
    parameter int PAGES_PER_GROUP = 128,
    parameter int FW     = $clog2(PAGES_PER_GROUP + 1),
    parameter int SW     = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1,
    parameter int PAW    = (GROUP_SLOTS * PAGES_PER_GROUP > 1) ?
                           $clog2(GROUP_SLOTS * PAGES_PER_GROUP) : 1,
    parameter int META_W = spgt_pkg::GROUP_W + spgt_pkg::COUNT_W + FW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  spgt_pkg::in_item_t    req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output spgt_pkg::out_item_t   res,
    output logic                  meta_we,
    output logic [SW-1:0]         meta_waddr,
    output logic [META_W-1:0]     meta_wdata,
    output logic [SW-1:0]         meta_raddr,
    input  logic [META_W-1:0]     meta_rdata,
    output logic                  page_we,
    output logic [PAW-1:0]        page_waddr,
    output logic [spgt_pkg::ADDR_W-1:0] page_wdata,
    output logic [PAW-1:0]        page_raddr,
    input  logic [spgt_pkg::ADDR_W-1:0] page_rdata
);
    import spgt_pkg::*;

    localparam int NW = $clog2(GROUP_SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SLOT = 3'd2;
    localparam logic [2:0] S_PAGE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [NW-1:0]      num_reg, num_next;
    logic [NW-1:0]      sidx_reg, sidx_next;
    logic [FW-1:0]      kidx_reg, kidx_next;
    logic               pend_reg, pend_next;
    logic [SW-1:0]      pslot_reg, pslot_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [PAW-1:0]     base_reg, base_next;
    out_item_t          res_reg, res_next;

    logic [GROUP_W-1:0] id_u;
    logic               no_group;
    logic [GROUP_W-1:0] rd_grp;
    logic [COUNT_W-1:0] rd_cnt;
    logic [FW-1:0]      rd_fill;
    logic               slot_hit;
    logic               page_hit;
    logic [COUNT_W-1:0] cnt_new;

    assign id_u     = $unsigned(item_reg.group_id);
    assign no_group = (id_u == NO_GROUP);
    assign rd_grp   = meta_rdata[META_W-1 -: GROUP_W];
    assign rd_cnt   = meta_rdata[FW+COUNT_W-1 -: COUNT_W];
    assign rd_fill  = meta_rdata[FW-1:0];
    assign slot_hit = pend_reg && (rd_grp == id_u);
    assign page_hit = pend_reg && (page_rdata == item_reg.page_addr);

    always_comb
    begin
        case (item_reg.action)
            ACT_INC:  cnt_new = (rd_cnt < COUNT_MAX) ? rd_cnt + 7'd1 : rd_cnt;
            ACT_DEC:  cnt_new = (rd_cnt != 7'd0) ? rd_cnt - 7'd1 : rd_cnt;
            default:  cnt_new = rd_cnt;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        num_next   = num_reg;
        sidx_next  = sidx_reg;
        kidx_next  = kidx_reg;
        pend_next  = 1'b0;
        pslot_next = pslot_reg;
        slot_next  = slot_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        meta_we    = 1'b0;
        meta_waddr = slot_reg;
        meta_wdata = {id_u, cnt_reg, fill_reg};
        meta_raddr = sidx_reg[SW-1:0];
        page_we    = 1'b0;
        page_waddr = base_reg + PAW'(fill_reg);
        page_wdata = item_reg.page_addr;
        page_raddr = base_reg + PAW'(kidx_reg);
        req_ready  = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_next  = '{status: ST_OK, is_member: 1'b0, proc_count: '0};
                sidx_next = '0;
                case (item_reg.action)
                    ACT_CREATE:
                    begin
                        state_next = S_DONE;
                        if (!no_group)
                        begin
                            if (num_reg == NW'(GROUP_SLOTS))
                            begin
                                res_next.status = ST_TABLE_FULL;
                            end
                            else
                            begin
                                meta_we    = 1'b1;
                                meta_waddr = num_reg[SW-1:0];
                                meta_wdata = {id_u, {COUNT_W{1'b0}}, {FW{1'b0}}};
                                num_next   = num_reg + NW'(1);
                            end
                        end
                    end
                    ACT_ADD, ACT_TEST:
                    begin
                        state_next = no_group ? S_DONE : S_SLOT;
                    end
                    ACT_INC, ACT_DEC, ACT_READ:
                    begin
                        state_next = S_SLOT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SLOT:
            begin
                if (slot_hit)
                begin
                    slot_next           = pslot_reg;
                    cnt_next            = rd_cnt;
                    fill_next           = rd_fill;
                    base_next           = PAW'(pslot_reg * PAGES_PER_GROUP);
                    kidx_next           = '0;
                    res_next.proc_count = rd_cnt;
                    if (item_reg.action == ACT_ADD || item_reg.action == ACT_TEST)
                    begin
                        state_next = (item_reg.page_addr == '0) ? S_DONE : S_PAGE;
                    end
                    else
                    begin
                        meta_we             = 1'b1;
                        meta_waddr          = pslot_reg;
                        meta_wdata          = {id_u, cnt_new, rd_fill};
                        res_next.proc_count = cnt_new;
                        state_next          = S_DONE;
                    end
                end
                else if (sidx_reg < num_reg)
                begin
                    meta_raddr = sidx_reg[SW-1:0];
                    pend_next  = 1'b1;
                    pslot_next = sidx_reg[SW-1:0];
                    sidx_next  = sidx_reg + NW'(1);
                end
                else if (!pend_reg)
                begin
                    res_next.status = ST_NO_GROUP;
                    state_next      = S_DONE;
                end
            end
            S_PAGE:
            begin
                if (page_hit)
                begin
                    res_next.is_member = (item_reg.action == ACT_TEST);
                    state_next         = S_DONE;
                end
                else if (kidx_reg < fill_reg)
                begin
                    page_raddr = base_reg + PAW'(kidx_reg);
                    pend_next  = 1'b1;
                    kidx_next  = kidx_reg + FW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_DONE;
                    if (item_reg.action == ACT_ADD)
                    begin
                        if (fill_reg >= FW'(PAGES_PER_GROUP))
                        begin
                            res_next.status = ST_LIST_FULL;
                        end
                        else
                        begin
                            page_we    = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {id_u, cnt_reg, fill_reg + FW'(1)};
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        sidx_reg  <= sidx_next;
        kidx_reg  <= kidx_next;
        pslot_reg <= pslot_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

### hw/rtl/shared_page_group_table.sv
// ----------------------------------------------------------------------------
// shared_page_group_table
// one item at a time: create and unused codes go straight to the result, count
//   operations scan the slot memory, add and test scan the slot then the page
//   memory (unless the id is NO_GROUP or the page address is zero); both scans
//   issue one read a cycle
// reset: control and the used-slot count clear at once; no memory clearing pass
// ----------------------------------------------------------------------------
module shared_page_group_table #(
    parameter int GROUP_SLOTS     = spgt_pkg::GROUP_SLOTS_DEF,
    parameter int PAGES_PER_GROUP = spgt_pkg::PAGES_PER_GROUP_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spgt_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output spgt_pkg::out_item_t rsp
);
    import spgt_pkg::*;

`include "shared_page_group_table_assert.svh"

    localparam int FW     = $clog2(PAGES_PER_GROUP + 1);
    localparam int SW     = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int PDEPTH = GROUP_SLOTS * PAGES_PER_GROUP;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int META_W = GROUP_W + COUNT_W + FW;

    logic                res_valid;
    logic                res_ready;
    out_item_t           res;
    logic                rsp_valid_reg, rsp_valid_next;
    out_item_t           rsp_reg, rsp_next;

    logic                meta_we;
    logic [SW-1:0]       meta_waddr;
    logic [META_W-1:0]   meta_wdata;
    logic [SW-1:0]       meta_raddr;
    logic [META_W-1:0]   meta_rdata;
    logic                page_we;
    logic [PAW-1:0]      page_waddr;
    logic [ADDR_W-1:0]   page_wdata;
    logic [PAW-1:0]      page_raddr;
    logic [ADDR_W-1:0]   page_rdata;

    spgt_seq #(
        .GROUP_SLOTS     (GROUP_SLOTS),
        .PAGES_PER_GROUP (PAGES_PER_GROUP),
        .FW              (FW),
        .SW              (SW),
        .PAW             (PAW),
        .META_W          (META_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .meta_raddr (meta_raddr),
        .meta_rdata (meta_rdata),
        .page_we    (page_we),
        .page_waddr (page_waddr),
        .page_wdata (page_wdata),
        .page_raddr (page_raddr),
        .page_rdata (page_rdata)
    );

    spgt_ram #(
        .WIDTH (META_W),
        .DEPTH (GROUP_SLOTS),
        .AW    (SW)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    spgt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (PDEPTH),
        .AW    (PAW)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    // output register parts the sequencer from the consumer
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SPGT_CHECK_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
    `SPGT_CHECK_NEXT(a_result_loaded, res_valid && res_ready, rsp_valid)
    `SPGT_CHECK(a_member_ok, rsp_valid && rsp.is_member, rsp.status == ST_OK)
    `SPGT_CHECK(a_count_range, rsp_valid, rsp.proc_count <= COUNT_MAX)
    `SPGT_CHECK(a_fail_no_count, rsp_valid && (rsp.status == ST_NO_GROUP ||
        rsp.status == ST_TABLE_FULL), rsp.proc_count == '0)

endmodule

### dv/group_table_checker.sv
// ----------------------------------------------------------------------------
// group_table_checker
// watches both channels of the sharing-group table, keeps its own copy of
// the slots, counts and page lists, predicts the result of every accepted
// request item and compares each accepted result item field by field
// ----------------------------------------------------------------------------
module group_table_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  spgt_pkg::in_item_t  req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  spgt_pkg::out_item_t rsp,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import spgt_pkg::*;

    localparam int SLOTS = GROUP_SLOTS_DEF;
    localparam int PAGES = PAGES_PER_GROUP_DEF;

    logic               slot_taken [SLOTS];
    logic [GROUP_W-1:0] slot_id    [SLOTS];
    logic [COUNT_W-1:0] slot_procs [SLOTS];
    int                 slot_pages [SLOTS];
    logic [ADDR_W-1:0]  page_list  [SLOTS][PAGES];

    out_item_t expected_results [$];
    out_item_t want;
    out_item_t predicted;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h",
                 $realtime, what, got, exp_val);
        mismatches++;
    endtask

    function automatic int find_group(input logic [GROUP_W-1:0] id);
        if (id == NO_GROUP)
            return -1;
        for (int s = 0; s < SLOTS; s++)
            if (slot_taken[s] && slot_id[s] == id)
                return s;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int s = 0; s < SLOTS; s++)
            if (!slot_taken[s])
                return s;
        return -1;
    endfunction

    function automatic bit page_listed(input int s, input logic [ADDR_W-1:0] addr);
        if (addr == '0)
            return 1'b0;
        for (int k = 0; k < slot_pages[s]; k++)
            if (page_list[s][k] == addr)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic apply_group_op(input in_item_t it, output out_item_t res);
        int                 s;
        logic [GROUP_W-1:0] id;
        id  = it.group_id;
        res = '0;
        case (it.action)
            ACT_CREATE:
                if (id != NO_GROUP)
                begin
                    s = first_free_slot();
                    if (s < 0)
                        res.status = ST_TABLE_FULL;
                    else
                    begin
                        slot_taken[s] = 1'b1;
                        slot_id[s]    = id;
                        slot_procs[s] = '0;
                        slot_pages[s] = 0;
                    end
                end
            ACT_ADD:
                if (id != NO_GROUP)
                begin
                    s = find_group(id);
                    if (s < 0)
                        res.status = ST_NO_GROUP;
                    else
                    begin
                        res.proc_count = slot_procs[s];
                        if (it.page_addr != '0 && !page_listed(s, it.page_addr))
                        begin
                            if (slot_pages[s] >= PAGES)
                                res.status = ST_LIST_FULL;
                            else
                            begin
                                page_list[s][slot_pages[s]] = it.page_addr;
                                slot_pages[s]++;
                            end
                        end
                    end
                end
            ACT_TEST:
                if (id != NO_GROUP)
                begin
                    s = find_group(id);
                    if (s < 0)
                        res.status = ST_NO_GROUP;
                    else
                    begin
                        res.proc_count = slot_procs[s];
                        res.is_member  = page_listed(s, it.page_addr);
                    end
                end
            ACT_INC, ACT_DEC, ACT_READ:
            begin
                s = find_group(id);
                if (s < 0)
                    res.status = ST_NO_GROUP;
                else
                begin
                    if (it.action == ACT_INC && slot_procs[s] < COUNT_MAX)
                        slot_procs[s]++;
                    else if (it.action == ACT_DEC && slot_procs[s] > 0)
                        slot_procs[s]--;
                    res.proc_count = slot_procs[s];
                end
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_taken[s] = 1'b0;
                slot_procs[s] = '0;
                slot_pages[s] = 0;
            end
            expected_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result item with nothing pending", 64'(rsp), '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.is_member !== want.is_member)
                        report_mismatch("is_member", 64'(rsp.is_member),
                                        64'(want.is_member));
                    if (rsp.proc_count !== want.proc_count)
                        report_mismatch("proc_count", 64'(rsp.proc_count),
                                        64'(want.proc_count));
                end
            end
            if (req_valid && req_ready)
            begin
                apply_group_op(req, predicted);
                expected_results.push_back(predicted);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

### dv/shared_page_group_table_test.sv
// ----------------------------------------------------------------------------
// shared_page_group_table_test
// drives create, add, test, count and spare-code items into the sharing-group table:
// a directed opening on the corner cases, then random traffic with count,
// list-fill and table-fill bursts under three idling mixes; the checker
// predicts and compares every result item
// ----------------------------------------------------------------------------
module shared_page_group_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spgt_pkg::*;

    localparam logic [2:0]        ACT_SPARE_6    = 3'd6;
    localparam logic [2:0]        ACT_SPARE_7    = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_ONES      = '1;
    localparam int                ID_POOL        = 8;
    localparam int                ADDR_POOL      = 16;
    localparam int                PHASE_ITEMS    = 364;
    localparam int                HOLD_AT        = 200;
    localparam int                HOLD_CYCLES    = 300;
    localparam int                DRAIN_CYCLES   = 250;
    localparam int                WATCHDOG_LIMIT = 4000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;
    int        mismatches;
    int        outstanding;

    int send_idle_pct = 14;
    int recv_idle_pct = 50;
    int results_taken = 0;

    logic signed [GROUP_W-1:0] id_pool   [ID_POOL];
    logic        [ADDR_W-1:0]  addr_pool [ADDR_POOL];

    shared_page_group_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    group_table_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic in_item_t make_item(input logic [2:0] action,
                                           input logic signed [GROUP_W-1:0] id,
                                           input logic [ADDR_W-1:0] addr);
        in_item_t it;
        it.action    = action;
        it.group_id  = id;
        it.page_addr = addr;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return ACT_CREATE;
        if (r < 42)
            return ACT_ADD;
        if (r < 66)
            return ACT_TEST;
        if (r < 77)
            return ACT_INC;
        if (r < 86)
            return ACT_DEC;
        if (r < 94)
            return ACT_READ;
        if (r < 97)
            return ACT_SPARE_6;
        return ACT_SPARE_7;
    endfunction

    function automatic logic signed [GROUP_W-1:0] pick_id();
        int          r;
        logic [31:0] w;
        r = $urandom_range(99);
        w = $urandom();
        if (r < 70)
            return id_pool[$urandom_range(ID_POOL-1)];
        if (r < 80)
            return NO_GROUP;
        return w[GROUP_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 50)
            return addr_pool[$urandom_range(ADDR_POOL-1)];
        return random_addr();
    endfunction

    // valid stays up between back-to-back items, drops only for a gap
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        if (rsp_valid && rsp_ready)
            results_taken <= results_taken + 1;

    initial
    begin : result_sink
        bit held;
        held = 1'b0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_taken == HOLD_AT)
            begin
                // long hold-off so the block fills up and stalls requests
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0]       w;
        logic [ADDR_W-1:0] a;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        id_pool[0] = 16'sd0;
        id_pool[1] = 16'sd32767;
        id_pool[2] = 16'sd1;
        id_pool[3] = -16'sd2;
        for (int i = 4; i < ID_POOL; i++)
        begin
            w = $urandom_range(32767);
            id_pool[i] = w[GROUP_W-1:0];
        end
        addr_pool[0] = 56'd1;
        addr_pool[1] = ADDR_ONES;
        addr_pool[2] = {1'b1, {(ADDR_W-1){1'b0}}};
        for (int i = 3; i < ADDR_POOL; i++)
            addr_pool[i] = random_addr();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, no group, creates with duplicate id
        send_item(make_item(ACT_TEST,   16'sd5,     56'd1));
        send_item(make_item(ACT_INC,    16'sd5,     '0));
        send_item(make_item(ACT_CREATE, NO_GROUP,   ADDR_ONES));
        send_item(make_item(ACT_CREATE, 16'sd0,     '0));
        send_item(make_item(ACT_CREATE, 16'sd32767, '0));
        send_item(make_item(ACT_CREATE, 16'sd0,     '0));
        // page adds: no group, zero, new, duplicate, missing group
        send_item(make_item(ACT_ADD,    NO_GROUP,   ADDR_ONES));
        send_item(make_item(ACT_ADD,    16'sd0,     '0));
        send_item(make_item(ACT_ADD,    16'sd0,     ADDR_ONES));
        send_item(make_item(ACT_ADD,    16'sd0,     ADDR_ONES));
        send_item(make_item(ACT_ADD,    16'sd0,     56'd1));
        send_item(make_item(ACT_ADD,    16'sd9,     56'd1));
        // membership tests
        send_item(make_item(ACT_TEST,   16'sd0,     ADDR_ONES));
        send_item(make_item(ACT_TEST,   16'sd0,     '0));
        send_item(make_item(ACT_TEST,   NO_GROUP,   56'd1));
        send_item(make_item(ACT_TEST,   16'sd32767, ADDR_ONES));
        send_item(make_item(ACT_TEST,   -16'sd32768, 56'd1));
        // counts, floor, missing group, spare codes
        send_item(make_item(ACT_DEC,    16'sd0,     '0));
        send_item(make_item(ACT_INC,    16'sd0,     '0));
        send_item(make_item(ACT_INC,    16'sd0,     '0));
        send_item(make_item(ACT_READ,   16'sd0,     '0));
        send_item(make_item(ACT_DEC,    16'sd0,     '0));
        send_item(make_item(ACT_INC,    NO_GROUP,   '0));
        send_item(make_item(ACT_READ,   16'sd32767, '0));
        send_item(make_item(ACT_SPARE_6, 16'sd0,    ADDR_ONES));
        send_item(make_item(ACT_SPARE_7, 16'sd0,    ADDR_ONES));

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    if (ph == 0)
                    begin
                        // count up past the ceiling and back below the floor
                        for (int k = 0; k < 66; k++)
                            send_item(make_item(ACT_INC, 16'sd0, random_addr()));
                        for (int k = 0; k < 66; k++)
                            send_item(make_item(ACT_DEC, 16'sd0, random_addr()));
                        send_item(make_item(ACT_READ, 16'sd0, '0));
                    end
                    else if (ph == 1)
                    begin
                        // fill one page list past its capacity
                        for (int k = 0; k < 132; k++)
                        begin
                            a = random_addr();
                            if (a == '0)
                                a = 56'd1;
                            send_item(make_item(ACT_ADD, 16'sd32767, a));
                        end
                        send_item(make_item(ACT_TEST, 16'sd32767, a));
                        send_item(make_item(ACT_TEST, 16'sd32767, random_addr()));
                    end
                    else
                    begin
                        // fill the group table
                        for (int k = 0; k < 66; k++)
                            send_item(make_item(ACT_CREATE, pick_id(), random_addr()));
                    end
                end
                send_item(make_item(pick_action(), pick_id(), pick_addr()));
            end
            if (ph == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/spgt_pkg.sv
hw/rtl/spgt_ram.sv
hw/rtl/spgt_seq.sv
hw/rtl/shared_page_group_table.sv
dv/group_table_checker.sv
dv/shared_page_group_table_test.sv
